FILE: rtl/dcbp_pkg.sv
// Package for the dictionary code bit packer.
// Holds the command codes, dictionary sizing, the lookup struct and the code width function.
// No dependencies.
package dcbp_pkg;

    localparam int DICT_SIZE = 8;
    localparam int IDX_W     = $clog2(DICT_SIZE);
    localparam int CNT_W     = $clog2(DICT_SIZE + 1);
    localparam int WID_W     = 4;

    typedef logic [1:0] t_cmd;

    localparam t_cmd CMD_LEARN  = 2'd0;
    localparam t_cmd CMD_ENCODE = 2'd1;
    localparam t_cmd CMD_FLUSH  = 2'd2;
    localparam t_cmd CMD_CLEAR  = 2'd3;

    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] idx;
    } t_lookup;

    // ceil(log2(n)), or 1 when n is 0 or 1; never above 8
    function automatic logic [WID_W-1:0] code_width(input logic [CNT_W-1:0] n);
        logic [WID_W-1:0] w;
        w = '0;
        for (int k = 1; k <= 8; k++) begin
            if (int'(n) > (1 << (k - 1))) begin
                w = w + WID_W'(1);
            end
        end
        if (n <= CNT_W'(1)) begin
            w = WID_W'(1);
        end
        return w;
    endfunction

endpackage

FILE: rtl/dictionary_code_bit_packer.sv
// Dictionary code bit packer, top level. An accepted item goes to the input register,
// then the result register. Throughput: one item per cycle unless the output stalls,
// set by the combinational dictionary compare and pack between the two registers.
// Reset (synchronous, active low) empties the dictionary, the bit buffer and both stages.
// Depends on dcbp_pkg, dcbp_dict and dcbp_pack.
module dictionary_code_bit_packer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_symbol,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_packed_byte,
    output logic       o_last
);

    // input stage
    logic                       r_in_valid;
    dcbp_pkg::t_cmd             r_cmd;
    logic [7:0]                 r_sym;

    // result stage
    logic                       r_out_valid;
    logic [7:0]                 r_out_byte;
    logic                       r_out_last;

    logic                       w_fire;
    dcbp_pkg::t_lookup          w_lookup;
    logic [dcbp_pkg::CNT_W-1:0] w_count;
    logic [dcbp_pkg::WID_W-1:0] w_width;
    logic                       w_res_valid;
    logic [7:0]                 w_res_byte;
    logic                       w_res_last;
    logic [2:0]                 w_fill;

    // Advance the held item once the result register is free or being drained.
    // Every item takes a slot here, so state updates stay in item order.
    assign w_fire  = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_cmd <= i_cmd;
            r_sym <= i_symbol;
        end
    end

    // Dictionary lookup and learn/clear against the held item
    dcbp_dict u_dict (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_upd    (w_fire),
        .i_cmd    (r_cmd),
        .i_symbol (r_sym),
        .o_lookup (w_lookup),
        .o_count  (w_count),
        .o_width  (w_width)
    );

    // Append the code or flush; a full byte or a flushed remainder is the result
    dcbp_pack u_pack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_upd       (w_fire),
        .i_cmd       (r_cmd),
        .i_lookup    (w_lookup),
        .i_width     (w_width),
        .o_res_valid (w_res_valid),
        .o_res_byte  (w_res_byte),
        .o_res_last  (w_res_last),
        .o_fill      (w_fill)
    );

    // Result register: load on fire, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= w_res_valid;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_res_valid) begin
            r_out_byte <= w_res_byte;
            r_out_last <= w_res_last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_packed_byte = r_out_byte;
    assign o_last        = r_out_last;

`ifndef ASSERT_OFF
    // a flush always leaves nothing pending
    a_flush_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (r_cmd == dcbp_pkg::CMD_FLUSH)) |=> (w_fill == 3'd0))
        else $error("bit buffer not empty after flush");

    // a clear always empties the dictionary
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (r_cmd == dcbp_pkg::CMD_CLEAR)) |=> (w_count == '0))
        else $error("dictionary count not zero after clear");

    // a hit never points at a dead entry
    a_hit_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && w_lookup.hit) |-> (dcbp_pkg::CNT_W'(w_lookup.idx) < w_count))
        else $error("lookup hit outside live entries");

    // a result without a fired item is impossible
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_fire))
        else $error("result appeared without a processed item");
`endif

endmodule

FILE: rtl/dcbp_dict.sv
// Symbol dictionary: entry store, parallel lookup and fill count.
// Depends on dcbp_pkg.
module dcbp_dict (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_upd,
    input  dcbp_pkg::t_cmd              i_cmd,
    input  logic [7:0]                  i_symbol,
    output dcbp_pkg::t_lookup           o_lookup,
    output logic [dcbp_pkg::CNT_W-1:0]  o_count,
    output logic [dcbp_pkg::WID_W-1:0]  o_width
);

    logic [7:0]                 r_dict [dcbp_pkg::DICT_SIZE];
    logic [dcbp_pkg::CNT_W-1:0] r_count;
    logic [dcbp_pkg::CNT_W-1:0] n_count;
    dcbp_pkg::t_lookup          w_lookup;
    logic                       w_add;

    // lowest matching live entry wins
    always_comb begin
        w_lookup.hit = 1'b0;
        w_lookup.idx = '0;
        for (int k = dcbp_pkg::DICT_SIZE - 1; k >= 0; k--) begin
            if ((k < int'(r_count)) && (r_dict[k] == i_symbol)) begin
                w_lookup.hit = 1'b1;
                w_lookup.idx = dcbp_pkg::IDX_W'(k);
            end
        end
    end

    assign w_add = (i_cmd == dcbp_pkg::CMD_LEARN) && !w_lookup.hit
                   && (i_symbol != dcbp_pkg::NEWLINE_BYTE)
                   && (r_count < dcbp_pkg::CNT_W'(dcbp_pkg::DICT_SIZE));

    always_comb begin
        n_count = r_count;
        if (i_upd && w_add) begin
            n_count = r_count + dcbp_pkg::CNT_W'(1);
        end else if (i_upd && (i_cmd == dcbp_pkg::CMD_CLEAR)) begin
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_upd && w_add) begin
            r_dict[r_count[dcbp_pkg::IDX_W-1:0]] <= i_symbol;
        end
    end

    assign o_lookup = w_lookup;
    assign o_count  = r_count;
    assign o_width  = dcbp_pkg::code_width(r_count);

endmodule

FILE: rtl/dcbp_pack.sv
// Bit packer: pending bit buffer, code append and byte or flush result.
// Depends on dcbp_pkg.
module dcbp_pack (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_upd,
    input  dcbp_pkg::t_cmd              i_cmd,
    input  dcbp_pkg::t_lookup           i_lookup,
    input  logic [dcbp_pkg::WID_W-1:0]  i_width,
    output logic                        o_res_valid,
    output logic [7:0]                  o_res_byte,
    output logic                        o_res_last,
    output logic [2:0]                  o_fill
);

    logic [7:0]  r_buf;
    logic [2:0]  r_fill;
    logic [7:0]  n_buf;
    logic [2:0]  n_fill;
    logic [3:0]  w_total;
    logic [15:0] w_acc;

    assign w_total = 4'(r_fill) + i_width;
    assign w_acc   = {r_buf, 8'h00}
                   | (16'(i_lookup.idx) << (5'd16 - 5'(w_total)));

    always_comb begin
        n_buf       = r_buf;
        n_fill      = r_fill;
        o_res_valid = 1'b0;
        o_res_byte  = r_buf;
        o_res_last  = 1'b0;
        unique case (i_cmd)
            dcbp_pkg::CMD_ENCODE: begin
                if (i_lookup.hit) begin
                    if (w_total >= 4'd8) begin
                        o_res_valid = 1'b1;
                        o_res_byte  = w_acc[15:8];
                        n_buf       = w_acc[7:0];
                        n_fill      = 3'(w_total - 4'd8);
                    end else begin
                        n_buf  = w_acc[15:8];
                        n_fill = w_total[2:0];
                    end
                end
            end
            dcbp_pkg::CMD_FLUSH: begin
                if (r_fill != 3'd0) begin
                    o_res_valid = 1'b1;
                    o_res_last  = 1'b1;
                    n_buf       = 8'h00;
                    n_fill      = 3'd0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf  <= 8'h00;
            r_fill <= 3'd0;
        end else if (i_upd) begin
            r_buf  <= n_buf;
            r_fill <= n_fill;
        end
    end

    assign o_fill = r_fill;

endmodule
